FILE: rtl/core/pfc_pkg.sv
`timescale 1ns / 1ps

package pfc_pkg;

    // Letters are coded a = 0 to z = 25; a square cell index runs 0 to 24, row-major.
    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_idx_t;
    typedef logic [2:0] kind_t;
    typedef logic [2:0] coord_t;

    localparam int NUM_LETTERS = 26;
    localparam int NUM_CELLS   = 25;
    localparam int SIDE        = 5;

    localparam letter_t LETTER_I = 5'd8;
    localparam letter_t LETTER_J = 5'd9;

    // Item kinds.
    localparam kind_t KIND_KEY     = 3'd0;
    localparam kind_t KIND_CLOSE   = 3'd1;
    localparam kind_t KIND_ENCRYPT = 3'd2;
    localparam kind_t KIND_DECRYPT = 3'd3;
    localparam kind_t KIND_NEW_KEY = 3'd4;

    // The letters i and j share one cell, so j is always looked up as i.
    function automatic letter_t merge_j(input letter_t c);
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

    // Folds a stored position back into the square; positions are always below 25.
    function automatic cell_idx_t wrap_cell(input cell_idx_t p);
        return (p >= cell_idx_t'(NUM_CELLS)) ? cell_idx_t'(p - cell_idx_t'(NUM_CELLS)) : p;
    endfunction

    function automatic coord_t row_of(input cell_idx_t p);
        coord_t r;
        if (p >= 5'd20)
            r = 3'd4;
        else if (p >= 5'd15)
            r = 3'd3;
        else if (p >= 5'd10)
            r = 3'd2;
        else if (p >= 5'd5)
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

    function automatic coord_t col_of(input cell_idx_t p);
        cell_idx_t rem;
        rem = cell_idx_t'(p - cell_idx_t'(row_of(p)) * cell_idx_t'(SIDE));
        return rem[2:0];
    endfunction

    // One step along a row or column: forward for encryption, back for decryption.
    function automatic coord_t step_coord(input coord_t c, input logic back);
        logic [3:0] sum;
        sum = back ? ({1'b0, c} + 4'(SIDE - 1)) : ({1'b0, c} + 4'd1);
        if (sum >= 4'(SIDE))
            sum = sum - 4'(SIDE);
        return sum[2:0];
    endfunction

    function automatic cell_idx_t cell_at(input coord_t r, input coord_t c);
        return cell_idx_t'(cell_idx_t'(r) * cell_idx_t'(SIDE) + cell_idx_t'(c));
    endfunction

endpackage

FILE: rtl/core/playfair_digraph_cipher_top.sv
// Playfair cipher with an on-line key square builder. Send key letters (kind 0), then a close
// item (kind 1) to fill the rest of the alphabet and complete the square; afterwards each
// encrypt (kind 2) or decrypt (kind 3) item returns the transformed pair, and a new key item
// (kind 4) starts over. Every item gives exactly one result item. Items are processed one at
// a time: a key letter, new key or unused kind goes straight to the output register load; a pair
// reads both letter positions from the position memory, then reads both result
// cells from the square memory, then loads the output register; and a close item on an
// incomplete square first walks the 25 letters a to z other than j through
// the memory write port one per cycle. A result waiting in the output register does not hold
// up the next item until that item's own result is due.
`timescale 1ns / 1ps

module playfair_digraph_cipher_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pfc_pkg::kind_t   kind,
    input  pfc_pkg::letter_t letter_a,
    input  pfc_pkg::letter_t letter_b,
    output logic             result_valid,
    input  logic             result_stall,
    output pfc_pkg::letter_t out_a,
    output pfc_pkg::letter_t out_b,
    output logic             square_ready
);
    import pfc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POS,
        S_FILL,
        S_RESULT
    } state_t;

    // Key square storage: the letter in each cell, and the cell of each placed letter.
    letter_t   square_cells [NUM_CELLS];
    cell_idx_t letter_position [NUM_LETTERS];

    state_t                   state_reg;
    logic [NUM_LETTERS-1:0]   used_reg;
    cell_idx_t                fill_count_reg;
    logic                     complete_reg;
    letter_t                  walk_reg;
    logic                     decrypt_reg;
    logic                     res_pair_reg;
    logic                     res_ready_reg;
    cell_idx_t                pos_a_reg;
    cell_idx_t                pos_b_reg;
    letter_t                  cell_a_reg;
    letter_t                  cell_b_reg;
    letter_t                  out_a_reg;
    letter_t                  out_b_reg;
    logic                     ready_out_reg;
    logic                     result_valid_reg;

    logic      accept;
    logic      is_pair;
    logic      pair_ok;
    letter_t   key_c;
    letter_t   place_c;
    logic      place_en;
    logic      place_ok;
    letter_t   pos_addr_a;
    letter_t   pos_addr_b;
    cell_idx_t pa;
    cell_idx_t pb;
    coord_t    r1;
    coord_t    c1;
    coord_t    r2;
    coord_t    c2;
    cell_idx_t na;
    cell_idx_t nb;
    logic      out_free;
    letter_t   walk_next;

    // Input handshake: one item in flight at a time.
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    assign is_pair = (kind == KIND_ENCRYPT) || (kind == KIND_DECRYPT);
    assign pair_ok = accept && is_pair && complete_reg
                     && (letter_a < letter_t'(NUM_LETTERS))
                     && (letter_b < letter_t'(NUM_LETTERS));

    // Letter placement is shared by key letters and the closing walk.
    assign key_c    = merge_j(letter_a);
    assign place_c  = (state_reg == S_FILL) ? walk_reg : key_c;
    assign place_en = (state_reg == S_FILL)
                      || (accept && (kind == KIND_KEY) && !complete_reg);
    assign place_ok = place_en && (place_c < letter_t'(NUM_LETTERS))
                      && (fill_count_reg < cell_idx_t'(NUM_CELLS))
                      && !used_reg[place_c];

    // The closing walk skips j, which is covered by i.
    assign walk_next = (walk_reg == LETTER_I) ? letter_t'(LETTER_J + 5'd1)
                                              : letter_t'(walk_reg + 5'd1);

    assign pos_addr_a = merge_j(letter_a);
    assign pos_addr_b = merge_j(letter_b);

    // Playfair rules on the two positions read in the previous cycle.
    always_comb
    begin
        pa = wrap_cell(pos_a_reg);
        pb = wrap_cell(pos_b_reg);
        r1 = row_of(pa);
        c1 = col_of(pa);
        r2 = row_of(pb);
        c2 = col_of(pb);
        if (r1 == r2)
        begin
            na = cell_at(r1, step_coord(c1, decrypt_reg));
            nb = cell_at(r2, step_coord(c2, decrypt_reg));
        end
        else if (c1 == c2)
        begin
            na = cell_at(step_coord(r1, decrypt_reg), c1);
            nb = cell_at(step_coord(r2, decrypt_reg), c2);
        end
        else
        begin
            na = cell_at(r1, c2);
            nb = cell_at(r2, c1);
        end
    end

    // Position memory: written as letters are placed, read twice for a pair.
    always_ff @(posedge clk)
    begin
        if (place_ok)
            letter_position[place_c] <= fill_count_reg;
        if (pair_ok)
        begin
            pos_a_reg <= letter_position[pos_addr_a];
            pos_b_reg <= letter_position[pos_addr_b];
        end
    end

    // Square memory: written in fill order, read twice for the result letters.
    always_ff @(posedge clk)
    begin
        if (place_ok)
            square_cells[fill_count_reg] <= place_c;
        if (state_reg == S_POS)
        begin
            cell_a_reg <= square_cells[na];
            cell_b_reg <= square_cells[nb];
        end
    end

    // Control sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            used_reg         <= '0;
            fill_count_reg   <= '0;
            complete_reg     <= 1'b0;
            walk_reg         <= '0;
            decrypt_reg      <= 1'b0;
            res_pair_reg     <= 1'b0;
            res_ready_reg    <= 1'b0;
            out_a_reg        <= '0;
            out_b_reg        <= '0;
            ready_out_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (place_ok)
            begin
                used_reg[place_c] <= 1'b1;
                fill_count_reg    <= cell_idx_t'(fill_count_reg + 5'd1);
            end

            // The consumer has taken the held item.
            if (result_valid_reg && !result_stall && (state_reg != S_RESULT))
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_pair_reg <= 1'b0;
                        decrypt_reg  <= (kind == KIND_DECRYPT);
                        state_reg    <= S_RESULT;
                        case (kind)
                            KIND_KEY:
                                res_ready_reg <= complete_reg;
                            KIND_CLOSE:
                            begin
                                res_ready_reg <= 1'b1;
                                if (!complete_reg)
                                begin
                                    walk_reg  <= '0;
                                    state_reg <= S_FILL;
                                end
                            end
                            KIND_ENCRYPT, KIND_DECRYPT:
                            begin
                                res_ready_reg <= pair_ok;
                                res_pair_reg  <= pair_ok;
                                if (pair_ok)
                                    state_reg <= S_POS;
                            end
                            KIND_NEW_KEY:
                            begin
                                used_reg       <= '0;
                                fill_count_reg <= '0;
                                complete_reg   <= 1'b0;
                                res_ready_reg  <= 1'b0;
                            end
                            default:
                                res_ready_reg <= complete_reg;
                        endcase
                    end
                end
                S_POS:
                    state_reg <= S_RESULT;
                S_FILL:
                begin
                    if (walk_reg == letter_t'(NUM_LETTERS - 1))
                    begin
                        complete_reg <= 1'b1;
                        state_reg    <= S_RESULT;
                    end
                    else
                        walk_reg <= walk_next;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        out_a_reg        <= res_pair_reg ? cell_a_reg : '0;
                        out_b_reg        <= res_pair_reg ? cell_b_reg : '0;
                        ready_out_reg    <= res_ready_reg;
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign out_a        = out_a_reg;
    assign out_b        = out_b_reg;
    assign square_ready = ready_out_reg;

    // The square never holds more than 25 letters.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= cell_idx_t'(NUM_CELLS))
        else $error("fill count beyond square size");

    // A result that is not ready carries zero letters.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !square_ready) |-> (out_a == '0 && out_b == '0))
        else $error("letters on a result that is not ready");

    // The closing walk only runs on an incomplete square.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> !complete_reg)
        else $error("fill walk on a complete square");

    // An accepted item is always followed by work or a result load.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted item dropped");

endmodule
